/* design/xtl_pkg.sv */
`default_nettype none

package xtl_pkg;

	// Parse phases
	localparam logic [3:0] PH_LT         = 4'd0;
	localparam logic [3:0] PH_AFTER_LT   = 4'd1;
	localparam logic [3:0] PH_NAME_START = 4'd2;
	localparam logic [3:0] PH_NAME       = 4'd3;
	localparam logic [3:0] PH_CLOSE_WS   = 4'd4;
	localparam logic [3:0] PH_GAP        = 4'd5;
	localparam logic [3:0] PH_ANAME      = 4'd6;
	localparam logic [3:0] PH_EQ_WS      = 4'd7;
	localparam logic [3:0] PH_VAL_WS     = 4'd8;
	localparam logic [3:0] PH_UVAL       = 4'd9;
	localparam logic [3:0] PH_QVAL       = 4'd10;
	localparam logic [3:0] PH_SLASH      = 4'd11;

	// Status codes
	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_NO_LT    = 3'd2;
	localparam logic [2:0] ST_BAD_NAME = 3'd3;
	localparam logic [2:0] ST_NO_EQ    = 3'd4;
	localparam logic [2:0] ST_BAD_END  = 3'd5;
	localparam logic [2:0] ST_NUL      = 3'd6;

	// Byte roles
	localparam logic [1:0] ROLE_MARKUP = 2'd0;
	localparam logic [1:0] ROLE_TAG    = 2'd1;
	localparam logic [1:0] ROLE_ANAME  = 2'd2;
	localparam logic [1:0] ROLE_AVAL   = 2'd3;

	// Tag kinds
	localparam logic [1:0] KIND_OPEN       = 2'd0;
	localparam logic [1:0] KIND_CLOSE      = 2'd1;
	localparam logic [1:0] KIND_OPEN_CLOSE = 2'd2;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef struct packed {
		logic [1:0] role;
		logic       attr_done;
		logic [2:0] status;
		logic [1:0] tag_kind;
	} lex_res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

`default_nettype wire

/* design/xml_tag_lexer.sv */
// Channel   Direction  Handshake                Payload
// ch        in         ch_valid / ch_ready      ch[7:0]
// res       out        res_valid / res_ready    ch_out, role, attr_done, attr_index,
//                                               status, tag_kind
//
// One word in, one word out. A byte is classified in the cycle it is accepted and
// its result sits in the output register from the next cycle on. Throughput is 1
// byte per cycle while the output drains, as each byte updates the phase register.
// ch_ready stays high while the output register is empty or being drained, so a
// stalled output holds one result and stops input only until it is taken.
// arst_n clears the phase, close flag, attribute count and output valid.
`default_nettype none

module xml_tag_lexer #(
	parameter int MAX_ATTR_INDEX = 15
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       ch_valid,
	output logic            ch_ready,
	input  wire logic [7:0] ch,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [7:0]      ch_out,
	output logic [1:0]      role,
	output logic            attr_done,
	output logic [3:0]      attr_index,
	output logic [2:0]      status,
	output logic [1:0]      tag_kind
);

	// The attribute index saturates at the smaller of the parameter and 15.
	localparam int          CAP_INT   = (MAX_ATTR_INDEX < 15) ? MAX_ATTR_INDEX : 15;
	localparam logic [3:0]  COUNT_CAP = CAP_INT[3:0];

	// Parse state, updated on every accepted byte
	logic [3:0] phase_q;
	logic       is_close_q;
	logic [3:0] attr_count_q;

	// Output register
	logic                 res_valid_q;
	logic [7:0]           ch_out_q;
	logic [3:0]           attr_index_q;
	xtl_pkg::lex_res_t    res_q;

	// Next-state logic
	xtl_pkg::lex_res_t    res_d;
	logic [3:0]           phase_d;
	logic                 is_close_d;
	logic                 accept;

	assign ch_ready = !res_valid_q || res_ready;
	assign accept   = ch_valid && ch_ready;

	// Classify the incoming byte against the current phase.
	always_comb begin
		res_d      = '{role: xtl_pkg::ROLE_MARKUP, attr_done: 1'b0,
			status: xtl_pkg::ST_BUSY, tag_kind: xtl_pkg::KIND_OPEN};
		phase_d    = phase_q;
		is_close_d = is_close_q;

		if (ch == xtl_pkg::CH_NUL) begin
			res_d.status = xtl_pkg::ST_NUL;
		end else begin
			unique case (phase_q)
				xtl_pkg::PH_AFTER_LT: begin
					if (ch == xtl_pkg::CH_SLASH) begin
						is_close_d = 1'b1;
						phase_d    = xtl_pkg::PH_NAME_START;
					end else if (xtl_pkg::is_letter(ch)) begin
						res_d.role = xtl_pkg::ROLE_TAG;
						phase_d    = xtl_pkg::PH_NAME;
					end else begin
						res_d.status = xtl_pkg::ST_BAD_NAME;
					end
				end
				xtl_pkg::PH_NAME_START: begin
					if (xtl_pkg::is_letter(ch)) begin
						res_d.role = xtl_pkg::ROLE_TAG;
						phase_d    = xtl_pkg::PH_NAME;
					end else begin
						res_d.status = xtl_pkg::ST_BAD_NAME;
					end
				end
				xtl_pkg::PH_NAME: begin
					if (xtl_pkg::is_ws(ch)) begin
						phase_d = is_close_q ? xtl_pkg::PH_CLOSE_WS : xtl_pkg::PH_GAP;
					end else if (ch == xtl_pkg::CH_GT) begin
						res_d.status   = xtl_pkg::ST_DONE;
						res_d.tag_kind = is_close_q ? xtl_pkg::KIND_CLOSE
							: xtl_pkg::KIND_OPEN;
					end else if (ch == xtl_pkg::CH_SLASH) begin
						if (is_close_q) begin
							res_d.status = xtl_pkg::ST_BAD_END;
						end else begin
							phase_d = xtl_pkg::PH_SLASH;
						end
					end else begin
						res_d.role = xtl_pkg::ROLE_TAG;
					end
				end
				xtl_pkg::PH_CLOSE_WS: begin
					if (ch == xtl_pkg::CH_GT) begin
						res_d.status   = xtl_pkg::ST_DONE;
						res_d.tag_kind = xtl_pkg::KIND_CLOSE;
					end else if (!xtl_pkg::is_ws(ch)) begin
						res_d.status = xtl_pkg::ST_BAD_END;
					end
				end
				xtl_pkg::PH_GAP: begin
					if (xtl_pkg::is_letter(ch)) begin
						res_d.role = xtl_pkg::ROLE_ANAME;
						phase_d    = xtl_pkg::PH_ANAME;
					end else if (ch == xtl_pkg::CH_SLASH) begin
						phase_d = xtl_pkg::PH_SLASH;
					end else if (ch == xtl_pkg::CH_GT) begin
						res_d.status = xtl_pkg::ST_DONE;
					end else if (!xtl_pkg::is_ws(ch)) begin
						res_d.status = xtl_pkg::ST_BAD_END;
					end
				end
				xtl_pkg::PH_ANAME: begin
					if (xtl_pkg::is_ws(ch)) begin
						phase_d = xtl_pkg::PH_EQ_WS;
					end else if (ch == xtl_pkg::CH_EQ) begin
						phase_d = xtl_pkg::PH_VAL_WS;
					end else if (ch == xtl_pkg::CH_SLASH || ch == xtl_pkg::CH_GT) begin
						res_d.status = xtl_pkg::ST_NO_EQ;
					end else begin
						res_d.role = xtl_pkg::ROLE_ANAME;
					end
				end
				xtl_pkg::PH_EQ_WS: begin
					if (ch == xtl_pkg::CH_EQ) begin
						phase_d = xtl_pkg::PH_VAL_WS;
					end else if (!xtl_pkg::is_ws(ch)) begin
						res_d.status = xtl_pkg::ST_NO_EQ;
					end
				end
				xtl_pkg::PH_VAL_WS: begin
					// Skip leading whitespace; a quote opens a quoted value.
					if (xtl_pkg::is_ws(ch)) begin
						phase_d = phase_q;
					end else if (ch == xtl_pkg::CH_QUOTE) begin
						phase_d = xtl_pkg::PH_QVAL;
					end else if (ch == xtl_pkg::CH_SLASH) begin
						res_d.attr_done = 1'b1;
						phase_d         = xtl_pkg::PH_SLASH;
					end else if (ch == xtl_pkg::CH_GT) begin
						res_d.attr_done = 1'b1;
						res_d.status    = xtl_pkg::ST_DONE;
					end else begin
						res_d.role = xtl_pkg::ROLE_AVAL;
						phase_d    = xtl_pkg::PH_UVAL;
					end
				end
				xtl_pkg::PH_UVAL: begin
					if (xtl_pkg::is_ws(ch)) begin
						res_d.attr_done = 1'b1;
						phase_d         = xtl_pkg::PH_GAP;
					end else if (ch == xtl_pkg::CH_SLASH) begin
						res_d.attr_done = 1'b1;
						phase_d         = xtl_pkg::PH_SLASH;
					end else if (ch == xtl_pkg::CH_GT) begin
						res_d.attr_done = 1'b1;
						res_d.status    = xtl_pkg::ST_DONE;
					end else begin
						res_d.role = xtl_pkg::ROLE_AVAL;
					end
				end
				xtl_pkg::PH_QVAL: begin
					if (ch == xtl_pkg::CH_QUOTE) begin
						res_d.attr_done = 1'b1;
						phase_d         = xtl_pkg::PH_GAP;
					end else begin
						res_d.role = xtl_pkg::ROLE_AVAL;
					end
				end
				xtl_pkg::PH_SLASH: begin
					if (ch == xtl_pkg::CH_GT) begin
						res_d.status   = xtl_pkg::ST_DONE;
						res_d.tag_kind = xtl_pkg::KIND_OPEN_CLOSE;
					end else begin
						res_d.status = xtl_pkg::ST_BAD_END;
					end
				end
				default: begin
					// Expect '<'; unused phase codes land here too.
					if (ch == xtl_pkg::CH_LT) begin
						phase_d = xtl_pkg::PH_AFTER_LT;
					end else begin
						res_d.status = xtl_pkg::ST_NO_LT;
					end
				end
			endcase
		end
	end

	// Advance the parse state; any final status restarts the lexer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= xtl_pkg::PH_LT;
			is_close_q   <= 1'b0;
			attr_count_q <= 4'd0;
		end else if (accept) begin
			if (res_d.status != xtl_pkg::ST_BUSY) begin
				phase_q      <= xtl_pkg::PH_LT;
				is_close_q   <= 1'b0;
				attr_count_q <= 4'd0;
			end else begin
				phase_q    <= phase_d;
				is_close_q <= is_close_d;
				if (res_d.attr_done && (attr_count_q < COUNT_CAP)) begin
					attr_count_q <= attr_count_q + 4'd1;
				end
			end
		end
	end

	// Output valid: set on accept, drop when taken with nothing new behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output payload: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_out_q     <= ch;
			attr_index_q <= attr_count_q;
			res_q        <= res_d;
		end
	end

	assign res_valid  = res_valid_q;
	assign ch_out     = ch_out_q;
	assign role       = res_q.role;
	assign attr_done  = res_q.attr_done;
	assign attr_index = attr_index_q;
	assign status     = res_q.status;
	assign tag_kind   = res_q.tag_kind;

`ifndef SYNTHESIS
	a_nul_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ch == xtl_pkg::CH_NUL) |=>
		(res_valid && status == xtl_pkg::ST_NUL && role == xtl_pkg::ROLE_MARKUP))
		else $error("NUL byte did not give NUL status");

	a_done_is_markup: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && attr_done) |-> (role == xtl_pkg::ROLE_MARKUP))
		else $error("attribute end byte carries a non-markup role");

	a_kind_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && tag_kind != xtl_pkg::KIND_OPEN) |-> (status == xtl_pkg::ST_DONE))
		else $error("tag kind set without done status");

	a_index_capped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (attr_index <= COUNT_CAP))
		else $error("attribute index above cap");
`endif

endmodule

`default_nettype wire

/* bench/xml_tag_lexer_check.sv */
`timescale 1ns / 100ps

module xml_tag_lexer_check #(
	parameter int MAX_ATTR_INDEX = 15
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       ch_valid,
	input  wire logic       ch_ready,
	input  wire logic [7:0] ch,
	input  wire logic       res_valid,
	input  wire logic       res_ready,
	input  wire logic [7:0] ch_out,
	input  wire logic [1:0] role,
	input  wire logic       attr_done,
	input  wire logic [3:0] attr_index,
	input  wire logic [2:0] status,
	input  wire logic [1:0] tag_kind,
	output int              mismatches,
	output int              outstanding
);
	import xtl_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] role;
		logic       attr_done;
		logic [3:0] attr_index;
		logic [2:0] status;
		logic [1:0] tag_kind;
	} token_t;

	localparam int COUNT_CAP = (MAX_ATTR_INDEX < 15) ? MAX_ATTR_INDEX : 15;

	logic [3:0] phase = PH_LT;
	logic       in_close = 1'b0;
	logic [3:0] attrs = '0;
	token_t     due_tokens[$];
	int         fails = 0;
	int         words_seen = 0;

	assign mismatches = fails;
	assign outstanding = due_tokens.size();

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_LF || c == CH_TAB;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	// Classify one byte against the tracked phase and advance it.
	task automatic lex_byte(input logic [7:0] c, output token_t t);
		logic [3:0] nxt;
		logic       closes_attr;
		nxt = phase;
		closes_attr = 1'b0;
		t = '0;
		t.ch = c;
		t.attr_index = attrs;
		t.role = ROLE_MARKUP;
		t.status = ST_BUSY;
		t.tag_kind = KIND_OPEN;
		if (c == CH_NUL) begin
			t.status = ST_NUL;
		end else begin
			case (phase)
			PH_AFTER_LT: begin
				if (c == CH_SLASH) begin
					in_close = 1'b1;
					nxt = PH_NAME_START;
				end else if (is_alpha(c)) begin
					t.role = ROLE_TAG;
					nxt = PH_NAME;
				end else begin
					t.status = ST_BAD_NAME;
				end
			end
			PH_NAME_START: begin
				if (is_alpha(c)) begin
					t.role = ROLE_TAG;
					nxt = PH_NAME;
				end else begin
					t.status = ST_BAD_NAME;
				end
			end
			PH_NAME: begin
				if (is_blank(c)) begin
					nxt = in_close ? PH_CLOSE_WS : PH_GAP;
				end else if (c == CH_GT) begin
					t.status = ST_DONE;
					t.tag_kind = in_close ? KIND_CLOSE : KIND_OPEN;
				end else if (c == CH_SLASH) begin
					if (in_close)
						t.status = ST_BAD_END;
					else
						nxt = PH_SLASH;
				end else begin
					t.role = ROLE_TAG;
				end
			end
			PH_CLOSE_WS: begin
				if (c == CH_GT) begin
					t.status = ST_DONE;
					t.tag_kind = KIND_CLOSE;
				end else if (!is_blank(c)) begin
					t.status = ST_BAD_END;
				end
			end
			PH_GAP: begin
				if (is_alpha(c)) begin
					t.role = ROLE_ANAME;
					nxt = PH_ANAME;
				end else if (c == CH_SLASH) begin
					nxt = PH_SLASH;
				end else if (c == CH_GT) begin
					t.status = ST_DONE;
				end else if (!is_blank(c)) begin
					t.status = ST_BAD_END;
				end
			end
			PH_ANAME: begin
				if (is_blank(c))
					nxt = PH_EQ_WS;
				else if (c == CH_EQ)
					nxt = PH_VAL_WS;
				else if (c == CH_SLASH || c == CH_GT)
					t.status = ST_NO_EQ;
				else
					t.role = ROLE_ANAME;
			end
			PH_EQ_WS: begin
				if (c == CH_EQ)
					nxt = PH_VAL_WS;
				else if (!is_blank(c))
					t.status = ST_NO_EQ;
			end
			PH_VAL_WS, PH_UVAL: begin
				// leading blanks before a value are skipped
				if (!(phase == PH_VAL_WS && is_blank(c))) begin
					if (phase == PH_VAL_WS && c == CH_QUOTE) begin
						nxt = PH_QVAL;
					end else if (is_blank(c)) begin
						closes_attr = 1'b1;
						nxt = PH_GAP;
					end else if (c == CH_SLASH) begin
						closes_attr = 1'b1;
						nxt = PH_SLASH;
					end else if (c == CH_GT) begin
						closes_attr = 1'b1;
						t.status = ST_DONE;
					end else begin
						t.role = ROLE_AVAL;
						nxt = PH_UVAL;
					end
				end
			end
			PH_QVAL: begin
				if (c == CH_QUOTE) begin
					closes_attr = 1'b1;
					nxt = PH_GAP;
				end else begin
					t.role = ROLE_AVAL;
				end
			end
			PH_SLASH: begin
				if (c == CH_GT) begin
					t.status = ST_DONE;
					t.tag_kind = KIND_OPEN_CLOSE;
				end else begin
					t.status = ST_BAD_END;
				end
			end
			default: begin
				if (c == CH_LT)
					nxt = PH_AFTER_LT;
				else
					t.status = ST_NO_LT;
			end
			endcase
		end
		t.attr_done = closes_attr;
		if (closes_attr && attrs < COUNT_CAP)
			attrs = attrs + 4'd1;
		if (t.status != ST_BUSY) begin
			phase = PH_LT;
			in_close = 1'b0;
			attrs = '0;
		end else begin
			phase = nxt;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		token_t got;
		if (!arst_n) begin
			phase = PH_LT;
			in_close = 1'b0;
			attrs = '0;
			due_tokens.delete();
		end else begin
			// retire the result first: it always belongs to an earlier byte
			if (res_valid && res_ready) begin
				got = {ch_out, role, attr_done, attr_index, status, tag_kind};
				if (due_tokens.size() == 0) begin
					if (fails < 10)
						$display("word %0d: unexpected %h %0d %b %0d %0d %0d",
							words_seen, got.ch, got.role, got.attr_done,
							got.attr_index, got.status, got.tag_kind);
					fails++;
				end else begin
					want = due_tokens.pop_front();
					if (got.ch !== want.ch || got.role !== want.role ||
					    got.attr_done !== want.attr_done ||
					    got.attr_index !== want.attr_index ||
					    got.status !== want.status || got.tag_kind !== want.tag_kind) begin
						if (fails < 10) begin
							$display("word %0d: expected ch=%h role=%0d done=%b",
								words_seen, want.ch, want.role, want.attr_done,
								"  idx=%0d st=%0d kind=%0d",
								want.attr_index, want.status, want.tag_kind);
							$display("word %0d:      got ch=%h role=%0d done=%b",
								words_seen, got.ch, got.role, got.attr_done,
								"  idx=%0d st=%0d kind=%0d",
								got.attr_index, got.status, got.tag_kind);
						end
						fails++;
					end
				end
				words_seen++;
			end
			if (ch_valid && ch_ready) begin
				lex_byte(ch, want);
				due_tokens.insert(due_tokens.size(), want);
			end
		end
	end

endmodule

/* bench/xml_tag_lexer_test.sv */
`timescale 1ns / 100ps

module xml_tag_lexer_test;
	import xtl_pkg::*;

	localparam int         BYTE_BUDGET = 800;
	localparam logic [7:0] UPPER_A = "A";
	localparam logic [7:0] LOWER_A = "a";
	localparam logic [7:0] DIGIT_0 = "0";

	// Receiver hold-off window, counted in the receiver's own cycles.
	localparam int HOLD_START = 150;
	localparam int HOLD_LEN   = 80;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       ch_valid = 1'b0;
	logic [7:0] ch = '0;
	logic       res_ready = 1'b0;
	logic       ch_ready;
	logic       res_valid;
	logic [7:0] ch_out;
	logic [1:0] role;
	logic       attr_done;
	logic [3:0] attr_index;
	logic [2:0] status;
	logic [1:0] tag_kind;

	int         mismatches;
	int         outstanding;
	int         cycle_no = 0;
	int         sent = 0;
	logic       calm;
	logic [7:0] tag_text[$];

	xml_tag_lexer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch_valid  (ch_valid),
		.ch_ready  (ch_ready),
		.ch        (ch),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ch_out    (ch_out),
		.role      (role),
		.attr_done (attr_done),
		.attr_index(attr_index),
		.status    (status),
		.tag_kind  (tag_kind)
	);

	xml_tag_lexer_check chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch_valid   (ch_valid),
		.ch_ready   (ch_ready),
		.ch         (ch),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.ch_out     (ch_out),
		.role       (role),
		.attr_done  (attr_done),
		.attr_index (attr_index),
		.status     (status),
		.tag_kind   (tag_kind),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_no <= cycle_no + 1;

	// Neither side idles inside this window.
	assign calm = cycle_no >= 400 && cycle_no < 700;

	function automatic logic blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_LF || c == CH_TAB;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(2))
		0: return CH_SPACE;
		1: return CH_LF;
		default: return CH_TAB;
		endcase
	endfunction

	function automatic logic [7:0] pick_alpha();
		logic [7:0] base;
		base = $urandom_range(1) ? UPPER_A : LOWER_A;
		return base + 8'($urandom_range(25));
	endfunction

	// Name bytes: mostly letters and digits, a share of arbitrary bytes so
	// that the high bits get exercised. Drop anything that would end a name.
	function automatic logic [7:0] pick_name_char(input logic in_attr);
		logic [7:0] c;
		do begin
			case ($urandom_range(3))
			0: c = 8'($urandom_range(255, 1));
			1: c = DIGIT_0 + 8'($urandom_range(9));
			default: c = pick_alpha();
			endcase
		end while (blank(c) || c == CH_SLASH || c == CH_GT || (in_attr && c == CH_EQ));
		return c;
	endfunction

	// Value bytes: quoted values take anything but the quote and NUL,
	// unquoted ones stop at blanks, '/' and '>' and skip the quote.
	function automatic logic [7:0] pick_value_char(input logic quoted);
		logic [7:0] c;
		do
			c = 8'($urandom_range(255, 1));
		while (c == CH_QUOTE || (!quoted && (blank(c) || c == CH_SLASH || c == CH_GT)));
		return c;
	endfunction

	// Append one byte to the end of the text queue.
	task automatic put_byte(input logic [7:0] b);
		tag_text.insert(tag_text.size(), b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// Append one well-formed tag with random content to the text queue.
	task automatic build_tag();
		logic [1:0] kind;
		int         nattr;
		int         style;
		logic       prev_quoted;
		kind = 2'($urandom_range(2));
		put_byte(CH_LT);
		if (kind == KIND_CLOSE)
			put_byte(CH_SLASH);
		put_byte(pick_alpha());
		repeat ($urandom_range(4)) put_byte(pick_name_char(1'b0));
		if (kind == KIND_CLOSE) begin
			repeat ($urandom_range(2)) put_byte(pick_blank());
			put_byte(CH_GT);
		end else begin
			// now and then run the attribute index into saturation
			nattr = ($urandom_range(19) == 0) ? $urandom_range(18, 14) : $urandom_range(3);
			prev_quoted = 1'b0;
			for (int i = 0; i < nattr; i++) begin
				// a quoted value needs no blank before the next attribute
				repeat (prev_quoted ? $urandom_range(2) : $urandom_range(2, 1))
					put_byte(pick_blank());
				put_byte(pick_alpha());
				repeat ($urandom_range(3)) put_byte(pick_name_char(1'b1));
				repeat ($urandom_range(1)) put_byte(pick_blank());
				put_byte(CH_EQ);
				repeat ($urandom_range(1)) put_byte(pick_blank());
				// 0..2 quoted, 3..4 unquoted, 5 empty (only on the last one)
				style = $urandom_range(5);
				if (style == 5 && i != nattr - 1)
					style = 3;
				prev_quoted = style <= 2;
				if (prev_quoted) begin
					put_byte(CH_QUOTE);
					repeat ($urandom_range(4)) put_byte(pick_value_char(1'b1));
					put_byte(CH_QUOTE);
				end else if (style != 5) begin
					repeat ($urandom_range(4, 1)) put_byte(pick_value_char(1'b0));
				end
			end
			repeat ($urandom_range(1)) put_byte(pick_blank());
			if (kind == KIND_OPEN_CLOSE)
				put_byte(CH_SLASH);
			put_byte(CH_GT);
		end
	endtask

	// Offer one word; hold it until accepted. Gaps go in before the word so
	// valid never drops while a word is pending.
	task automatic push_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 6) begin
			ch_valid <= 1'b0;
			@(negedge clk);
		end
		ch <= b;
		ch_valid <= 1'b1;
		@(posedge clk);
		while (!ch_ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic feed_text();
		while (tag_text.size() != 0)
			push_byte(tag_text.pop_front());
	endtask

	// Sender: directed tags, then random tags until the budget is spent.
	initial begin
		logic paused;
		paused = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a stray top byte, a digit after '<', a slash inside a
		// close tag, a plain close, an empty value before "/>", a name
		// without '=', and a NUL inside a quoted value.
		put_byte(8'hFF);
		put_text("<1");
		put_text("</a/");
		put_text("</b>");
		put_text("<a b=/>");
		put_text("<c d/");
		put_text("<e f=\"");
		put_byte(CH_NUL);
		feed_text();

		while (sent < BYTE_BUDGET) begin
			// Once, halfway, drop valid and let the pipeline drain completely.
			if (!paused && sent >= BYTE_BUDGET / 2) begin
				paused = 1'b1;
				ch_valid <= 1'b0;
				@(negedge clk);
				while (outstanding != 0) @(negedge clk);
			end
			// stray bytes between tags, mostly missing-bracket errors
			if ($urandom_range(99) < 8)
				put_byte(8'($urandom_range(255)));
			build_tag();
			// break some tags: overwrite one byte, or cut the tag short
			if ($urandom_range(99) < 12)
				tag_text[$urandom_range(tag_text.size() - 1)] = 8'($urandom_range(255));
			if ($urandom_range(99) < 5)
				repeat ($urandom_range(tag_text.size() - 1)) void'(tag_text.pop_back());
			feed_text();
		end
		ch_valid <= 1'b0;

		// Drain, then let the output register settle before the final check.
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver: random stalls, one long hold-off that backs the block up
	// into its input, and no stalls inside the calm window.
	initial begin
		int rx_cycles;
		rx_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
				res_ready <= 1'b0;
			else
				res_ready <= calm || $urandom_range(99) >= 6;
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

endmodule
